// ===== sv/nrps_pkg.sv =====
// Shared types, codes and constants of the reader poll sequencer.
`default_nettype none
package nrps_pkg;

  typedef enum logic [2:0] {
    PH_INITIAL   = 3'd0,
    PH_STARTUP   = 3'd1,
    PH_CONFIG_ACK = 3'd2,
    PH_IDLE      = 3'd3,
    PH_RF_ACK    = 3'd4,
    PH_CARDS_ACK = 3'd5,
    PH_CARDS     = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_ACK     = 3'd1,
    CMD_SAM_CFG = 3'd2,
    CMD_RF_ON   = 3'd3,
    CMD_AUTOPOLL = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REP_NONE    = 2'd0,
    REP_UID     = 2'd1,
    REP_NO_CARD = 2'd2,
    REP_UNKNOWN = 2'd3
  } rep_t;

  typedef enum logic [2:0] {
    REG_STARTUP_DELAY   = 3'd0,
    REG_READY_DELAY     = 3'd1,
    REG_ACK_POLL_DELAY  = 3'd2,
    REG_PROBE_INTERVAL  = 3'd3,
    REG_WAIT_LIMIT      = 3'd4,
    REG_CARDS_ACK_LIMIT = 3'd5
  } reg_index_t;

  localparam logic [15:0] STARTUP_DELAY_RST   = 16'd500;
  localparam logic [15:0] READY_DELAY_RST     = 16'd100;
  localparam logic [15:0] ACK_POLL_DELAY_RST  = 16'd10;
  localparam logic [15:0] PROBE_INTERVAL_RST  = 16'd100;
  localparam logic [31:0] WAIT_LIMIT_RST      = 32'd5000;
  localparam logic [31:0] CARDS_ACK_LIMIT_RST = 32'd10000;

  localparam logic [7:0] KIND_A      = 8'h10;
  localparam logic [7:0] KIND_B      = 8'h20;
  localparam logic [7:0] KIND_LONG   = 8'h11;
  localparam logic [7:0] LONG_UID_LEN = 8'd8;
  localparam logic [3:0] UID_OFF_STD  = 4'd14;
  localparam logic [3:0] UID_OFF_LONG = 4'd12;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        device_present;
    logic        write_ok;
    logic        ack_valid;
    logic        response_ready;
    logic [7:0]  card_count;
    logic [7:0]  card_kind;
    logic [7:0]  uid_len_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] report;
    logic [7:0] uid_length;
    logic [3:0] uid_offset;
    logic       timed_out;
    logic [2:0] phase;
  } out_word_t;

endpackage
`default_nettype wire

// ===== sv/nrps_if.sv =====
// Valid/ready channel interfaces for poll words and result words.
`default_nettype none
interface nrps_in_if;
  logic               valid;
  logic               ready;
  nrps_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nrps_out_if;
  logic                valid;
  logic                ready;
  nrps_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/nfc_reader_poll_sequencer_unit.sv =====
// Reader bring-up and polling sequencer: input register, step logic, result register.
// The input register holds an accepted poll word and the result register its result word.
// Throughput: one word per cycle unless out_ch stalls; the step logic is one phase decode
// with two 32-bit subtract-and-compare paths between the input and result registers.
// Reset (rst, synchronous): phase initial, both time stamps zero, registers to defaults,
// both stages empty.
`default_nettype none
module nfc_reader_poll_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [31:0] wr_data,
  nrps_in_if.sink          in_ch,
  nrps_out_if.source       out_ch
);

  logic [15:0] startup_delay, ready_delay, ack_poll_delay, probe_interval;
  logic [31:0] wait_limit, cards_ack_limit;

  nrps_pkg::phase_t phase_reg;
  nrps_pkg::phase_t phase_next;
  logic [31:0] last_step_time, phase_change_time;

  logic                in_full;
  nrps_pkg::in_word_t  in_word;
  logic                res_full;
  nrps_pkg::out_word_t res_word;

  logic        advance;
  logic [31:0] elapsed, since_change, delay, limit;
  logic        act, expired;
  nrps_pkg::cmd_t cmd;
  nrps_pkg::rep_t rep;
  logic [7:0]  len;
  logic [3:0]  off;
  logic        tmo;

  assign advance      = in_full && (!res_full || out_ch.ready);
  assign in_ch.ready  = !in_full || advance;
  assign out_ch.valid = res_full;
  assign out_ch.data  = res_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_delay   <= nrps_pkg::STARTUP_DELAY_RST;
      ready_delay     <= nrps_pkg::READY_DELAY_RST;
      ack_poll_delay  <= nrps_pkg::ACK_POLL_DELAY_RST;
      probe_interval  <= nrps_pkg::PROBE_INTERVAL_RST;
      wait_limit      <= nrps_pkg::WAIT_LIMIT_RST;
      cards_ack_limit <= nrps_pkg::CARDS_ACK_LIMIT_RST;
    end else if (wr_en) begin
      unique case (nrps_pkg::reg_index_t'(wr_index))
        nrps_pkg::REG_STARTUP_DELAY:   startup_delay   <= wr_data[15:0];
        nrps_pkg::REG_READY_DELAY:     ready_delay     <= wr_data[15:0];
        nrps_pkg::REG_ACK_POLL_DELAY:  ack_poll_delay  <= wr_data[15:0];
        nrps_pkg::REG_PROBE_INTERVAL:  probe_interval  <= wr_data[15:0];
        nrps_pkg::REG_WAIT_LIMIT:      wait_limit      <= wr_data;
        nrps_pkg::REG_CARDS_ACK_LIMIT: cards_ack_limit <= wr_data;
        default: ;
      endcase
    end
  end

  // timing checks
  assign elapsed      = in_word.now_ms - last_step_time;
  assign since_change = in_word.now_ms - phase_change_time;

  always_comb begin
    delay = {16'd0, ack_poll_delay};
    limit = wait_limit;
    case (phase_reg)
      nrps_pkg::PH_INITIAL:   delay = {16'd0, startup_delay};
      nrps_pkg::PH_STARTUP:   delay = {16'd0, ready_delay};
      nrps_pkg::PH_IDLE:      delay = {16'd0, probe_interval};
      nrps_pkg::PH_CARDS_ACK: limit = cards_ack_limit;
      default: ;
    endcase
  end

  assign act = (elapsed >= delay) ||
               !(phase_reg == nrps_pkg::PH_INITIAL || phase_reg == nrps_pkg::PH_STARTUP ||
                 phase_reg == nrps_pkg::PH_CONFIG_ACK || phase_reg == nrps_pkg::PH_IDLE ||
                 phase_reg == nrps_pkg::PH_RF_ACK || phase_reg == nrps_pkg::PH_CARDS_ACK ||
                 phase_reg == nrps_pkg::PH_CARDS);
  assign expired = since_change > limit;

  // next phase
  always_comb begin
    phase_next = phase_reg;
    if (act) begin
      unique case (phase_reg)
        nrps_pkg::PH_INITIAL:
          if (in_word.device_present) phase_next = nrps_pkg::PH_STARTUP;
        nrps_pkg::PH_STARTUP:
          phase_next = in_word.write_ok ? nrps_pkg::PH_CONFIG_ACK : nrps_pkg::PH_INITIAL;
        nrps_pkg::PH_CONFIG_ACK:
          if (in_word.ack_valid) phase_next = nrps_pkg::PH_IDLE;
          else if (expired) phase_next = nrps_pkg::PH_INITIAL;
        nrps_pkg::PH_IDLE:
          phase_next = in_word.write_ok ? nrps_pkg::PH_RF_ACK : nrps_pkg::PH_INITIAL;
        nrps_pkg::PH_RF_ACK:
          if (in_word.ack_valid) begin
            phase_next = in_word.write_ok ? nrps_pkg::PH_CARDS_ACK : nrps_pkg::PH_INITIAL;
          end else if (expired) begin
            phase_next = nrps_pkg::PH_INITIAL;
          end
        nrps_pkg::PH_CARDS_ACK:
          if (in_word.ack_valid) phase_next = nrps_pkg::PH_CARDS;
          else if (expired) phase_next = nrps_pkg::PH_INITIAL;
        nrps_pkg::PH_CARDS:
          if (in_word.response_ready) phase_next = nrps_pkg::PH_IDLE;
          else if (expired) phase_next = nrps_pkg::PH_INITIAL;
        default: phase_next = nrps_pkg::PH_INITIAL;
      endcase
    end
  end

  // step outputs
  always_comb begin
    cmd = nrps_pkg::CMD_NONE;
    rep = nrps_pkg::REP_NONE;
    len = 8'd0;
    off = 4'd0;
    tmo = 1'b0;
    if (act) begin
      unique case (phase_reg) inside
        nrps_pkg::PH_INITIAL:
          if (in_word.device_present) cmd = nrps_pkg::CMD_ACK;
        nrps_pkg::PH_STARTUP: cmd = nrps_pkg::CMD_SAM_CFG;
        nrps_pkg::PH_CONFIG_ACK, nrps_pkg::PH_CARDS_ACK:
          tmo = !in_word.ack_valid && expired;
        nrps_pkg::PH_IDLE: cmd = nrps_pkg::CMD_RF_ON;
        nrps_pkg::PH_RF_ACK:
          if (in_word.ack_valid) cmd = nrps_pkg::CMD_AUTOPOLL;
          else tmo = expired;
        nrps_pkg::PH_CARDS:
          if (in_word.response_ready) begin
            cmd = nrps_pkg::CMD_ACK;
            if (in_word.card_count == 8'd0) begin
              rep = nrps_pkg::REP_NO_CARD;
            end else begin
              case (in_word.card_kind) inside
                nrps_pkg::KIND_A, nrps_pkg::KIND_B: begin
                  rep = nrps_pkg::REP_UID;
                  len = in_word.uid_len_byte;
                  off = nrps_pkg::UID_OFF_STD;
                end
                nrps_pkg::KIND_LONG: begin
                  rep = nrps_pkg::REP_UID;
                  len = nrps_pkg::LONG_UID_LEN;
                  off = nrps_pkg::UID_OFF_LONG;
                end
                default: rep = nrps_pkg::REP_UNKNOWN;
              endcase
            end
          end else begin
            tmo = expired;
          end
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word <= in_ch.data;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg         <= nrps_pkg::PH_INITIAL;
      last_step_time    <= 32'd0;
      phase_change_time <= 32'd0;
    end else if (advance) begin
      phase_reg <= phase_next;
      if (act) begin
        last_step_time <= in_word.now_ms;
        if (phase_next != phase_reg) phase_change_time <= in_word.now_ms;
      end
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (out_ch.ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_word.command    <= cmd;
      res_word.report     <= rep;
      res_word.uid_length <= len;
      res_word.uid_offset <= off;
      res_word.timed_out  <= tmo;
      res_word.phase      <= phase_next;
    end
  end

endmodule
`default_nettype wire
